/* rtl/core/arc_pkg.sv */
// Package for the ack range coalescer: widths, packet id codes,
// the record type carried through the queue and the front status struct.
// No dependencies.
package arc_pkg;

  localparam int unsigned SeqW   = 24;
  localparam int unsigned CntW   = 16;
  localparam int unsigned IdW    = 8;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QLvlW  = $clog2(QDepth + 1);

  localparam logic [SeqW-1:0] SeqMax = '1;
  localparam logic [IdW-1:0]  IdNack = 8'hA0;
  localparam logic [IdW-1:0]  IdAck  = 8'hC0;

  typedef struct packed {
    logic            kind;
    logic [SeqW-1:0] first;
    logic [SeqW-1:0] final_seq;
    logic [CntW-1:0] count;
    logic            fin;
  } rec_t;

  typedef struct packed {
    logic [1:0] n_push;
    logic       run_open;
  } front_stat_t;

endpackage

/* rtl/core/arc_front.sv */
// Front end of the ack range coalescer: holds the open run and turns each
// accepted sequence number into zero, one or two records.
// Depends on arc_pkg.
module arc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [arc_pkg::SeqW-1:0] seq_num_i,
  input  logic                     last_number_i,
  input  logic                     is_ack_i,
  output arc_pkg::rec_t            rec0_o,
  output arc_pkg::rec_t            rec1_o,
  output arc_pkg::front_stat_t     stat_o
);
  import arc_pkg::*;

  logic            open_q, open_d;
  logic            kind_q, kind_d;
  logic [SeqW-1:0] beg_q, beg_d;
  logic [SeqW-1:0] end_q, end_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      n_push;
  rec_t            rec_f;

  always_comb begin
    open_d = open_q;
    kind_d = kind_q;
    beg_d  = beg_q;
    end_d  = end_q;
    cnt_d  = cnt_q;
    rec0_o = '0;
    rec1_o = '0;
    rec_f  = '0;
    n_push = 2'd0;
    if (accept_i) begin
      if (!open_q) begin
        kind_d = is_ack_i;
        cnt_d  = '0;
        beg_d  = seq_num_i;
        end_d  = seq_num_i;
        open_d = 1'b1;
      end else if (end_q != SeqMax && seq_num_i == end_q + 1'b1) begin
        end_d = seq_num_i;
      end else if (seq_num_i != end_q) begin
        rec0_o = '{kind_q, beg_q, end_q, cnt_q + 1'b1, 1'b0};
        n_push = 2'd1;
        cnt_d  = cnt_q + 1'b1;
        beg_d  = seq_num_i;
        end_d  = seq_num_i;
      end
      if (last_number_i) begin
        rec_f  = '{kind_d, beg_d, end_d, cnt_d + 1'b1, 1'b1};
        cnt_d  = cnt_d + 1'b1;
        open_d = 1'b0;
        if (n_push == 2'd0) begin
          rec0_o = rec_f;
        end else begin
          rec1_o = rec_f;
        end
        n_push = n_push + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      kind_q <= 1'b0;
      beg_q  <= '0;
      end_q  <= '0;
      cnt_q  <= '0;
    end else begin
      open_q <= open_d;
      kind_q <= kind_d;
      beg_q  <= beg_d;
      end_q  <= end_d;
      cnt_q  <= cnt_d;
    end
  end

  assign stat_o = '{n_push: n_push, run_open: open_q};

endmodule

/* rtl/core/arc_queue.sv */
// Record queue between front and back of the ack range coalescer:
// up to two writes and one read per cycle.
// Depends on arc_pkg.
module arc_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  arc_pkg::rec_t             rec0_i,
  input  arc_pkg::rec_t             rec1_i,
  input  arc_pkg::front_stat_t      stat_i,
  input  logic                      pop_i,
  output arc_pkg::rec_t             head_o,
  output logic                      full_o,
  output logic                      empty_o,
  output logic [arc_pkg::QLvlW-1:0] level_o
);
  import arc_pkg::*;

  rec_t             mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, wp_d;
  logic [QPtrW-1:0] rp_q, rp_d;
  logic [QLvlW-1:0] lvl_q, lvl_d;
  logic             pop_acc;

  assign empty_o = (lvl_q == '0);
  assign full_o  = (lvl_q > QLvlW'(QDepth - 2));
  assign pop_acc = pop_i && !empty_o;
  assign head_o  = mem_q[rp_q];
  assign level_o = lvl_q;

  always_comb begin
    wp_d  = wp_q + QPtrW'(stat_i.n_push);
    rp_d  = rp_q + QPtrW'(pop_acc);
    lvl_d = lvl_q + QLvlW'(stat_i.n_push) - QLvlW'(pop_acc);
  end

  always_ff @(posedge clk_i) begin
    if (stat_i.n_push != 2'd0) begin
      mem_q[wp_q] <= rec0_i;
    end
    if (stat_i.n_push == 2'd2) begin
      mem_q[wp_q + 1'b1] <= rec1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      lvl_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      lvl_q <= lvl_d;
    end
  end

endmodule

/* rtl/core/ack_range_coalescer.sv */
// Top level of the ack range coalescer: front end, record queue and
// record formatting onto the result ports.
// Depends on arc_pkg, arc_front, arc_queue.
//
//   channel  | handshake         | payload
//   ---------+-------------------+-----------------------------------------
//   request  | push / full       | seq_num_i, last_number_i, is_ack_i
//   record   | empty / pop       | packet_id_o, single_flag_o, range_first_o,
//            |                   | range_final_o, records_so_far_o,
//            |                   | final_record_o
//
// One request is taken per cycle while full is low; the run state is
// registered. A record shows on the result ports while at the queue head.
// A request makes zero, one or two records; the four-entry record queue
// raises full while fewer than two entries are free, so the sustained rate
// is set by how fast records are popped.
// Reset clears the run state and the queue pointers; no clearing pass.
module ack_range_coalescer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [arc_pkg::SeqW-1:0] seq_num_i,
  input  logic                     last_number_i,
  input  logic                     is_ack_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [arc_pkg::IdW-1:0]  packet_id_o,
  output logic                     single_flag_o,
  output logic [arc_pkg::SeqW-1:0] range_first_o,
  output logic [arc_pkg::SeqW-1:0] range_final_o,
  output logic [arc_pkg::CntW-1:0] records_so_far_o,
  output logic                     final_record_o
);
  import arc_pkg::*;

  logic             accept;
  rec_t             rec0, rec1, head;
  front_stat_t      fstat;
  logic [QLvlW-1:0] level;

  assign accept = push && !full;

  arc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .seq_num_i     (seq_num_i),
    .last_number_i (last_number_i),
    .is_ack_i      (is_ack_i),
    .rec0_o        (rec0),
    .rec1_o        (rec1),
    .stat_o        (fstat)
  );

  arc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rec0_i  (rec0),
    .rec1_i  (rec1),
    .stat_i  (fstat),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty),
    .level_o (level)
  );

  assign packet_id_o      = head.kind ? IdAck : IdNack;
  assign single_flag_o    = (head.first == head.final_seq);
  assign range_first_o    = head.first;
  assign range_final_o    = head.final_seq;
  assign records_so_far_o = head.count;
  assign final_record_o   = head.fin;

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= QLvlW'(QDepth))
    else $error("record queue level above depth");

  a_first_item_one_rec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !fstat.run_open) |-> (fstat.n_push <= 2'd1))
    else $error("packet start produced a closing record");

  a_two_recs_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fstat.n_push == 2'd2) |-> (accept && last_number_i))
    else $error("two records without a last request");

  a_pop_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && fstat.n_push == 2'd0) |=> (level == $past(level) - 1'b1))
    else $error("pop did not drain the queue");

endmodule
